/* src/lru_handle_cache_assert.svh */
// assertion macros for the lru handle cache
`ifndef LRU_HANDLE_CACHE_ASSERT_SVH
`define LRU_HANDLE_CACHE_ASSERT_SVH

`ifndef ASSERT_OFF
`define LHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LHC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LHC_ASSERT(lbl, prop, msg)
`define LHC_NEVER(lbl, cond, msg)
`endif

`endif

/* src/lhc_pkg.sv */
// shared constants and types for the lru handle cache
package lhc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 32;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int CAP_RESET   = 16;
    localparam int OUT_DATA_W  = ((ID_W + OCC_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_DATA_W - ID_W - OCC_W;

    // request kinds
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } lhc_cmd_t;

endpackage

/* src/lru_handle_cache.sv */
// top level of the lru handle cache
//
// Fully associative LRU tracker of 32-bit ids with MAX_ENTRIES entries.
// Input stream: s_tuser is the request kind (0 access, 1 flush), s_tdata the id.
// Output stream: one result transfer per request; m_tuser holds the hit and
// eviction flags, m_tdata the evicted id and the occupancy after the request.
// Configuration: cfg_we with cfg_wdata writes the capacity (0 acts as 1, values
// above MAX_ENTRIES act as MAX_ENTRIES); write it only while the block is idle.
// A request accepted at one edge is compared and applied in the next cycle; the
// result register and m_tvalid are loaded at the end of that cycle, so the result
// transfer can happen once m_tvalid is high.
// The controller sequences one request at a time through the single compare/update
// stage, so no new request is accepted until the current one has executed.
// A single result register holds the answer; while it waits untaken, s_tready
// stays low, and a result taken in the same cycle lets the next request in.
// When the receiver stalls, at most one request is in flight and none is lost.
// Reset: all entries invalid, occupancy 0, capacity 16, no result pending.
module lru_handle_cache (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave side
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lhc_pkg::ID_W-1:0]              s_tdata,  // [31:0] item_id
    input  logic [0:0]                            s_tuser,  // [0] req_type
    // master side
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] evicted_id, [36:32] occupancy, [39:37] zero
    output logic [lhc_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [1:0]                            m_tuser,  // [0] was_hit, [1] evict_valid
    // configuration
    input  logic                                  cfg_we,
    input  logic [lhc_pkg::CAP_W-1:0]             cfg_wdata
);
    import lhc_pkg::*;

    `include "lru_handle_cache_assert.svh"

    lhc_cmd_t          cmd;
    logic              was_hit;
    logic              evict_valid;
    logic [ID_W-1:0]   evicted_id;
    logic [OCC_W-1:0]  occupancy;

    // controller
    lhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath
    lhc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_req_type     (s_tuser[0]),
        .in_item_id      (s_tdata),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_was_hit     (was_hit),
        .out_evict_valid (evict_valid),
        .out_evicted_id  (evicted_id),
        .out_occupancy   (occupancy)
    );

    // output packing
    assign m_tdata = {PAD_W'(0), occupancy, evicted_id};
    assign m_tuser = {evict_valid, was_hit};

    // checks
    `LHC_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
    `LHC_ASSERT(a_result_follows, (s_tvalid && s_tready) |-> ##2 m_tvalid, "result late")
    `LHC_NEVER(a_hit_and_evict, m_tvalid && m_tuser[0] && m_tuser[1], "hit with eviction")
    `LHC_NEVER(a_occ_range, m_tvalid && (32'(occupancy) > 32'(MAX_ENTRIES)), "occupancy high")

endmodule

/* src/lhc_ctrl.sv */
// controller: request sequencing and output handshake
module lhc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lhc_pkg::lhc_cmd_t cmd
);
    import lhc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // accept when idle and the output slot is free by the next cycle
    assign s_tready    = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign m_tvalid    = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set by an executed request, cleared by a transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/lhc_dp.sv */
// datapath: entry store, lookup, victim select, recency update, result register
module lhc_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lhc_pkg::lhc_cmd_t              cmd,
    input  logic                           in_req_type,
    input  logic [lhc_pkg::ID_W-1:0]       in_item_id,
    input  logic                           cfg_we,
    input  logic [lhc_pkg::CAP_W-1:0]      cfg_wdata,
    output logic                           out_was_hit,
    output logic                           out_evict_valid,
    output logic [lhc_pkg::ID_W-1:0]       out_evicted_id,
    output logic [lhc_pkg::OCC_W-1:0]      out_occupancy
);
    import lhc_pkg::*;

    // request and configuration
    logic                   req_type_reg;
    logic [ID_W-1:0]        req_id_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [CNT_W-1:0]       cap_eff;

    // entry state
    logic [ID_W-1:0]        ids_reg   [MAX_ENTRIES];
    logic [RANK_W-1:0]      rank_reg  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]       count_reg;

    // lookup results
    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] victim;
    logic [MAX_ENTRIES-1:0] evict_sel;
    logic [MAX_ENTRIES-1:0] valid_left;
    logic [MAX_ENTRIES-1:0] free_oh;
    logic                   hit;
    logic [RANK_W-1:0]      hit_rank;
    logic [RANK_W-1:0]      last_rank;
    logic                   need_evict;
    logic                   install;
    logic [ID_W-1:0]        evict_id;
    logic [CNT_W-1:0]       count_next;

    // result register
    logic                   was_hit_reg;
    logic                   evv_reg;
    logic [ID_W-1:0]        evid_reg;
    logic [OCC_W-1:0]       occ_reg;

    // capacity clamp to 1 .. MAX_ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(MAX_ENTRIES))
        begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    // parallel compare, victim select and free slot search
    always_comb
    begin
        hit      = 1'b0;
        hit_rank = '0;
        evict_id = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (ids_reg[i] == req_id_reg);
            hit      = hit | match[i];
            if (match[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
            end
        end
        need_evict = !hit && (count_reg >= cap_eff) && (count_reg != '0);
        last_rank  = RANK_W'(count_reg - CNT_W'(1));
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            victim[i]    = valid_reg[i] && (rank_reg[i] == last_rank);
            evict_sel[i] = need_evict && victim[i];
            if (evict_sel[i])
            begin
                evict_id = evict_id | ids_reg[i];
            end
        end
        valid_left = valid_reg & ~evict_sel;
        // lowest clear bit of the remaining valid mask
        free_oh    = ~valid_left & (valid_left + MAX_ENTRIES'(1));
        install    = !hit && (free_oh != '0);
        count_next = count_reg - CNT_W'(need_evict) + CNT_W'(install);
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= in_req_type;
            req_id_reg   <= in_item_id;
        end
    end

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // valid bits, ranks and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (req_type_reg == REQ_FLUSH)
            begin
                valid_reg <= '0;
                count_reg <= '0;
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end
            else if (hit)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (match[i])
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                end
            end
            else
            begin
                count_reg <= count_next;
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (free_oh[i])
                    begin
                        valid_reg[i] <= 1'b1;
                        rank_reg[i]  <= '0;
                    end
                    else if (valid_left[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                    else if (evict_sel[i])
                    begin
                        valid_reg[i] <= 1'b0;
                        rank_reg[i]  <= '0;
                    end
                end
            end
        end
    end

    // id store, written on install
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cmd.exec && (req_type_reg == REQ_ACCESS) && !hit && free_oh[i])
            begin
                ids_reg[i] <= req_id_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (req_type_reg == REQ_FLUSH)
            begin
                was_hit_reg <= 1'b0;
                evv_reg     <= 1'b0;
                evid_reg    <= '0;
                occ_reg     <= '0;
            end
            else
            begin
                was_hit_reg <= hit;
                evv_reg     <= need_evict;
                evid_reg    <= need_evict ? evict_id : '0;
                occ_reg     <= OCC_W'(hit ? count_reg : count_next);
            end
        end
    end

    assign out_was_hit     = was_hit_reg;
    assign out_evict_valid = evv_reg;
    assign out_evicted_id  = evid_reg;
    assign out_occupancy   = occ_reg;

endmodule
